// ===== src/orse_pkg.sv =====
package orse_pkg;

  typedef enum logic [1:0] {
    CMD_RESTART  = 2'd0,
    CMD_PRESENCE = 2'd1,
    CMD_BITPAIR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_MORE = 2'd0,
    ST_DONE = 2'd1,
    ST_FAIL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_PRESENCE = 2'd1,
    ERR_BUS      = 2'd2,
    ERR_CRC      = 2'd3
  } error_e;

  typedef enum logic [1:0] {
    REG_ALARM_ONLY = 2'd0,
    REG_CHECK_CRC  = 2'd1
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CODE_W    = 64;

  localparam logic [7:0] SEARCH_BYTE = 8'hF0;
  localparam logic [7:0] ALARM_BYTE  = 8'hEC;
  localparam logic [7:0] CRC_POLY    = 8'h8C;

  typedef struct packed {
    logic [1:0] command;
    logic       presence;
    logic       bit_true;
    logic       bit_complement;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        send_byte;
    logic              direction_bit;
    logic              write_valid;
    logic              found;
    logic [CODE_W-1:0] rom_code;
    logic [1:0]        search_status;
    logic [1:0]        error_code;
  } out_item_t;

  typedef struct packed {
    logic alarm_only;
    logic check_crc;
  } cfg_t;

endpackage

// ===== src/orse_step.sv =====
module orse_step import orse_pkg::*; #(
  parameter int unsigned ROM_BITS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  localparam int unsigned IW = $clog2(ROM_BITS);
  localparam int unsigned CW = $clog2(ROM_BITS + 1);

  logic [CW-1:0]       bit_index_q, bit_index_d;
  logic [ROM_BITS-1:0] code_q, code_d;
  logic [ROM_BITS-1:0] prev_code_q, prev_code_d;
  logic [CW-1:0]       prev_fork_q, prev_fork_d;
  logic                fork_valid_q, fork_valid_d;
  logic [IW-1:0]       fork_idx_q, fork_idx_d;
  logic                first_pass_q, first_pass_d;
  logic [7:0]          crc_q, crc_d;
  status_e             status_q, status_d;
  error_e              error_q, error_d;
  logic                pass_open_q, pass_open_d;

  logic [IW-1:0]       idx;
  logic                dir;
  logic                fb;
  logic [ROM_BITS-1:0] code_next;
  logic [7:0]          crc_next;
  out_item_t           res;

  assign idx = bit_index_q[IW-1:0];

  always_comb begin
    bit_index_d  = bit_index_q;
    code_d       = code_q;
    prev_code_d  = prev_code_q;
    prev_fork_d  = prev_fork_q;
    fork_valid_d = fork_valid_q;
    fork_idx_d   = fork_idx_q;
    first_pass_d = first_pass_q;
    crc_d        = crc_q;
    status_d     = status_q;
    error_d      = error_q;
    pass_open_d  = pass_open_q;
    res          = '0;
    dir          = item_i.bit_true;
    fb           = 1'b0;
    code_next    = code_q;
    crc_next     = crc_q;

    unique case (item_i.command)
      CMD_RESTART: begin
        prev_fork_d  = CW'(ROM_BITS);
        prev_code_d  = '0;
        status_d     = ST_MORE;
        error_d      = ERR_NONE;
        first_pass_d = 1'b1;
        pass_open_d  = 1'b0;
        bit_index_d  = '0;
        code_d       = '0;
        crc_d        = '0;
        fork_valid_d = 1'b0;
      end
      CMD_PRESENCE: begin
        if (status_q == ST_MORE) begin
          if (!item_i.presence) begin
            status_d     = ST_FAIL;
            error_d      = ERR_PRESENCE;
            pass_open_d  = 1'b0;
            first_pass_d = 1'b0;
          end else begin
            bit_index_d   = '0;
            code_d        = '0;
            crc_d         = '0;
            fork_valid_d  = 1'b0;
            pass_open_d   = 1'b1;
            res.send_byte = cfg_i.alarm_only ? ALARM_BYTE : SEARCH_BYTE;
          end
        end
      end
      CMD_BITPAIR: begin
        if (status_q == ST_MORE && pass_open_q) begin
          if (item_i.bit_true && item_i.bit_complement) begin
            status_d     = ST_FAIL;
            error_d      = ERR_BUS;
            pass_open_d  = 1'b0;
            first_pass_d = 1'b0;
          end else begin
            // both zero: devices disagree here, pick the branch
            if (!item_i.bit_true && !item_i.bit_complement) begin
              if (!first_pass_q && CW'(idx) < prev_fork_q) begin
                dir = prev_code_q[idx];
                if (!dir) begin
                  fork_valid_d = 1'b1;
                  fork_idx_d   = idx;
                end
              end else if (CW'(idx) == prev_fork_q) begin
                dir = 1'b1;
              end else begin
                fork_valid_d = 1'b1;
                fork_idx_d   = idx;
              end
            end
            code_next = code_q | (ROM_BITS'(dir) << idx);
            fb        = crc_q[0] ^ dir;
            crc_next  = (crc_q >> 1) ^ (fb ? CRC_POLY : 8'h00);
            code_d    = code_next;
            crc_d     = crc_next;
            bit_index_d       = bit_index_q + CW'(1);
            res.direction_bit = dir;
            res.write_valid   = 1'b1;
            if (bit_index_q == CW'(ROM_BITS - 1)) begin
              prev_code_d  = code_next;
              pass_open_d  = 1'b0;
              first_pass_d = 1'b0;
              if (cfg_i.check_crc && crc_next != 8'h00) begin
                status_d = ST_FAIL;
                error_d  = ERR_CRC;
              end else begin
                res.found                  = 1'b1;
                res.rom_code[ROM_BITS-1:0] = code_next;
                if (!fork_valid_d) begin
                  status_d = ST_DONE;
                end else begin
                  prev_fork_d = CW'(fork_idx_d);
                end
              end
            end
          end
        end
      end
      default: ;
    endcase

    res.search_status = status_d;
    res.error_code    = error_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_index_q  <= '0;
      code_q       <= '0;
      prev_code_q  <= '0;
      prev_fork_q  <= CW'(ROM_BITS);
      fork_valid_q <= 1'b0;
      fork_idx_q   <= '0;
      first_pass_q <= 1'b1;
      crc_q        <= '0;
      status_q     <= ST_MORE;
      error_q      <= ERR_NONE;
      pass_open_q  <= 1'b0;
    end else if (step_i) begin
      bit_index_q  <= bit_index_d;
      code_q       <= code_d;
      prev_code_q  <= prev_code_d;
      prev_fork_q  <= prev_fork_d;
      fork_valid_q <= fork_valid_d;
      fork_idx_q   <= fork_idx_d;
      first_pass_q <= first_pass_d;
      crc_q        <= crc_d;
      status_q     <= status_d;
      error_q      <= error_d;
      pass_open_q  <= pass_open_d;
    end
  end

endmodule

// ===== src/onewire_rom_search_engine.sv =====
// 1-Wire search-ROM sequencer. Each request on the input channel is one bus
// event: restart the search, the presence answer of a bus reset, or a read
// bit pair. Every request yields exactly one result on the output channel:
// the search byte to send (after a good presence), the branch bit to write
// back (bit pairs), a completed device code with its found flag, and the
// current search status and error code.
// A request is first captured in the input register; the step logic then
// loads the result register from it while updating the search state. One
// request per cycle is sustained while the receiver takes every result; the
// input register drains whenever the result register is empty or being
// taken.
// If the receiver stalls, the result register holds and the input register
// fills; input ready drops only when both are occupied.
// Reset clears the search state (no pass open, status "more", first pass)
// and the settings: alarm_only 0, check_crc 1. Settings are written on the
// configuration channel, which is always ready, and should change only while
// no request is in flight.
module onewire_rom_search_engine import orse_pkg::*; #(
  parameter int unsigned ROM_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i
);

  cfg_t      cfg_q;
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t step_res;
  logic      advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarm_only <= 1'b0;
      cfg_q.check_crc  <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ALARM_ONLY: cfg_q.alarm_only <= cfg_data_i;
        REG_CHECK_CRC:  cfg_q.check_crc  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  orse_step #(
    .ROM_BITS(ROM_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg_q),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
